>>> sv/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link supervisor client package
// Shared widths, codes and the record passed from front to back end.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int MAC_W      = 48;
    localparam int MS_W       = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = 2;
    localparam int ACT_W      = 3;
    localparam int MISS_W     = 2;

    localparam logic [MISS_W-1:0] MISS_SAT   = 2'd3;
    localparam logic [MISS_W-1:0] MISS_LIMIT = 2'd3;

    typedef logic [MAC_W-1:0] mac_t;
    typedef logic [MS_W-1:0]  ms_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADVERTISE  = 3'd0,
        ACT_ADD_PEER   = 3'd1,
        ACT_HANDSHAKE  = 3'd2,
        ACT_CONNECTED  = 3'd3,
        ACT_HB_REQUEST = 3'd4,
        ACT_LINK_LOST  = 3'd5
    } action_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_MESSAGE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_CONNECT   = 2'd0,
        KIND_ACK       = 2'd1,
        KIND_HEARTBEAT = 2'd2,
        KIND_OTHER     = 2'd3
    } msg_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OWN_MAC         = 3'd0,
        REG_BROADCAST       = 3'd1,
        REG_ADV_INTERVAL    = 3'd2,
        REG_CHECK_INTERVAL  = 3'd3,
        REG_SILENCE_TIMEOUT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        logic [MAX_RES-1:0][ACT_W-1:0]     act;
        logic [MAX_RES-1:0][MAC_W-1:0]     peer;
        logic [MAX_RES-1:0][MAC_W-1:0]     reply;
        logic                              running;
        logic                              advertising;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> sv/lsc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lsc_pkg::CFG_ADDR_W-1:0] addr;
    logic [lsc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> sv/lsc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Millisecond tick or received message summary, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [lsc_pkg::MS_W-1:0]  now_ms;
    logic [lsc_pkg::MAC_W-1:0] sender_mac;
    logic                      msg_ok;
    logic [1:0]                msg_kind;
    logic [lsc_pkg::MAC_W-1:0] msg_from;
    logic [lsc_pkg::MAC_W-1:0] msg_to;

    modport source (output valid, opcode, now_ms, sender_mac, msg_ok, msg_kind,
                    msg_from, msg_to, input ready);
    modport sink   (input valid, opcode, now_ms, sender_mac, msg_ok, msg_kind,
                    msg_from, msg_to, output ready);
endinterface

>>> sv/lsc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// One action per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsc_out_if;
    logic                      valid;
    logic                      ready;
    logic [lsc_pkg::ACT_W-1:0] action;
    logic [lsc_pkg::MAC_W-1:0] peer_addr;
    logic [lsc_pkg::MAC_W-1:0] reply_to;
    logic                      is_running;
    logic                      is_advertising;
    logic                      last;

    modport source (output valid, action, peer_addr, reply_to, is_running,
                    is_advertising, last, input ready);
    modport sink   (input valid, action, peer_addr, reply_to, is_running,
                    is_advertising, last, output ready);
endinterface

>>> sv/link_supervisor_client.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link supervisor client
// Client side of a peer link: advertising, connection and heartbeat watch.
// ----------------------------------------------------------------------------
// cfg writes one of five registers (own address, broadcast address, advertise
// interval, check interval, silence timeout); it is always ready and must be
// written only while no item is in flight.
// item carries a millisecond tick or a received message summary. An item is
// taken in the same cycle it is offered while the action queue has room, so
// a new item can be accepted every cycle.
// result carries zero to three actions per item, the final one flagged by
// last. The first action passes through the action queue and then the
// output register; the output stage then issues one action per cycle while
// result.ready is high. The action queue (QUEUE_DEPTH records) and the
// output register set how far the input runs ahead.
// When result is stalled the output register holds, the queue fills and
// item.ready drops once it is full.
// Reset restores the register defaults, starts advertising with all stamps,
// the miss count and the server address cleared, and empties the queue.
// ----------------------------------------------------------------------------
module link_supervisor_client #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    lsc_cfg_if.sink     cfg,
    lsc_in_if.sink      item,
    lsc_out_if.source   result
);

    logic                push_valid;
    logic                push_ready;
    lsc_pkg::bundle_t    push_data;
    logic                head_valid;
    lsc_pkg::bundle_t    head;
    logic                pop;
    lsc_pkg::q_status_t  q_status;

    lsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    lsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .status     (q_status)
    );

    lsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !q_status.full)
        else $error("push into full action queue");

    a_lost_restarts_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.action == lsc_pkg::ACT_LINK_LOST))
        |-> (!result.is_running && result.is_advertising && result.last))
        else $error("link lost without advertising restart");

    a_add_peer_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.action == lsc_pkg::ACT_ADD_PEER)) |-> !result.last)
        else $error("add peer not followed by handshake");

    a_handshake_stops_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.action == lsc_pkg::ACT_HANDSHAKE))
        |-> (result.last && !result.is_advertising))
        else $error("handshake while still advertising");

endmodule

>>> sv/lsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link supervisor front end
// Holds configuration and link state, classifies each item and builds the
// record of up to three actions it causes.
// ----------------------------------------------------------------------------
module lsc_front (
    input  logic                clk,
    input  logic                rst_n,
    lsc_cfg_if.sink             cfg,
    lsc_in_if.sink              item,
    input  logic                push_ready,
    output logic                push_valid,
    output lsc_pkg::bundle_t    push_data
);

    lsc_pkg::mac_t                   own_mac_reg;
    lsc_pkg::mac_t                   bcast_reg;
    lsc_pkg::ms_t                    adv_int_reg;
    lsc_pkg::ms_t                    chk_int_reg;
    lsc_pkg::ms_t                    sil_reg;

    logic                            adv_reg, adv_next;
    logic                            run_reg, run_next;
    lsc_pkg::ms_t                    adv_stamp_reg, adv_stamp_next;
    lsc_pkg::ms_t                    rcv_stamp_reg, rcv_stamp_next;
    lsc_pkg::ms_t                    chk_stamp_reg, chk_stamp_next;
    logic [lsc_pkg::MISS_W-1:0]      miss_reg, miss_next;
    lsc_pkg::mac_t                   server_reg, server_next;

    logic                            accept;
    lsc_pkg::ms_t                    rcv_eff;
    logic [lsc_pkg::MISS_W-1:0]      miss_inc;
    logic [lsc_pkg::RES_CNT_W-1:0]   n;
    lsc_pkg::bundle_t                b;

    assign cfg.ready  = 1'b1;
    assign item.ready = push_ready;
    assign accept     = item.valid && push_ready;

    always_comb
    begin
        adv_next       = adv_reg;
        run_next       = run_reg;
        adv_stamp_next = adv_stamp_reg;
        rcv_stamp_next = rcv_stamp_reg;
        chk_stamp_next = chk_stamp_reg;
        miss_next      = miss_reg;
        server_next    = server_reg;
        rcv_eff        = rcv_stamp_reg;
        miss_inc       = miss_reg;
        n              = '0;
        b              = '0;
        if (accept)
        begin
            if (item.opcode == lsc_pkg::OP_TICK)
            begin
                if (adv_reg)
                begin
                    rcv_eff        = item.now_ms;
                    rcv_stamp_next = item.now_ms;
                    if ((item.now_ms - adv_stamp_reg) > adv_int_reg)
                    begin
                        adv_stamp_next = item.now_ms;
                        b.act[n]       = lsc_pkg::ACT_ADVERTISE;
                        b.peer[n]      = bcast_reg;
                        b.reply[n]     = bcast_reg;
                        n              = n + 2'd1;
                    end
                end
                if (run_reg && ((item.now_ms - chk_stamp_reg) > chk_int_reg))
                begin
                    chk_stamp_next = item.now_ms;
                    if ((item.now_ms - rcv_eff) > sil_reg)
                    begin
                        b.act[n]   = lsc_pkg::ACT_HB_REQUEST;
                        b.peer[n]  = server_reg;
                        b.reply[n] = '0;
                        n          = n + 2'd1;
                        miss_inc   = (miss_reg == lsc_pkg::MISS_SAT) ? miss_reg
                                                                      : miss_reg + 2'd1;
                        miss_next  = miss_inc;
                        if (miss_inc >= lsc_pkg::MISS_LIMIT)
                        begin
                            server_next    = '0;
                            run_next       = 1'b0;
                            adv_next       = 1'b1;
                            adv_stamp_next = '0;
                            b.act[n]       = lsc_pkg::ACT_LINK_LOST;
                            b.peer[n]      = server_reg;
                            b.reply[n]     = '0;
                            n              = n + 2'd1;
                        end
                    end
                end
            end
            else if ((item.sender_mac != own_mac_reg) && item.msg_ok)
            begin
                rcv_stamp_next = item.now_ms;
                unique case (lsc_pkg::msg_kind_t'(item.msg_kind))
                    lsc_pkg::KIND_CONNECT:
                    begin
                        if (item.msg_to == own_mac_reg)
                        begin
                            b.act[0]   = lsc_pkg::ACT_ADD_PEER;
                            b.peer[0]  = item.msg_from;
                            b.reply[0] = '0;
                            b.act[1]   = lsc_pkg::ACT_HANDSHAKE;
                            b.peer[1]  = item.msg_from;
                            b.reply[1] = item.sender_mac;
                            n          = 2'd2;
                            adv_next   = 1'b0;
                        end
                    end
                    lsc_pkg::KIND_ACK:
                    begin
                        run_next    = 1'b1;
                        server_next = item.msg_from;
                        b.act[0]    = lsc_pkg::ACT_CONNECTED;
                        b.peer[0]   = item.msg_from;
                        b.reply[0]  = '0;
                        n           = 2'd1;
                    end
                    lsc_pkg::KIND_HEARTBEAT:
                    begin
                        miss_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        b.count       = n;
        b.running     = run_next;
        b.advertising = adv_next;
    end

    assign push_valid = accept && (n != '0);
    assign push_data  = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            bcast_reg   <= '1;
            adv_int_reg <= 32'd1000;
            chk_int_reg <= 32'd1000;
            sil_reg     <= 32'd3000;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                lsc_pkg::REG_OWN_MAC:         own_mac_reg <= cfg.data;
                lsc_pkg::REG_BROADCAST:       bcast_reg   <= cfg.data;
                lsc_pkg::REG_ADV_INTERVAL:    adv_int_reg <= cfg.data[lsc_pkg::MS_W-1:0];
                lsc_pkg::REG_CHECK_INTERVAL:  chk_int_reg <= cfg.data[lsc_pkg::MS_W-1:0];
                lsc_pkg::REG_SILENCE_TIMEOUT: sil_reg     <= cfg.data[lsc_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_reg       <= 1'b1;
            run_reg       <= 1'b0;
            adv_stamp_reg <= '0;
            rcv_stamp_reg <= '0;
            chk_stamp_reg <= '0;
            miss_reg      <= '0;
            server_reg    <= '0;
        end
        else
        begin
            adv_reg       <= adv_next;
            run_reg       <= run_next;
            adv_stamp_reg <= adv_stamp_next;
            rcv_stamp_reg <= rcv_stamp_next;
            chk_stamp_reg <= chk_stamp_next;
            miss_reg      <= miss_next;
            server_reg    <= server_next;
        end
    end

endmodule

>>> sv/lsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link supervisor action queue
// Short first-in first-out store of action records between front and back.
// ----------------------------------------------------------------------------
module lsc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  lsc_pkg::bundle_t    push_data,
    output logic                push_ready,
    output logic                head_valid,
    output lsc_pkg::bundle_t    head,
    input  logic                pop,
    output lsc_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsc_pkg::bundle_t   fifo_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign push_ready   = (count_reg != CNT_W'(DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head         = fifo_reg[rd_ptr_reg];
    assign status.full  = !push_ready;
    assign status.empty = !head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/lsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link supervisor back end
// Walks the head record one action at a time into the output register.
// ----------------------------------------------------------------------------
module lsc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lsc_pkg::bundle_t    head,
    output logic                pop,
    lsc_out_if.source           result
);

    logic [lsc_pkg::RES_CNT_W-1:0] slot_reg, slot_next;
    logic                          out_valid_reg;
    logic [lsc_pkg::ACT_W-1:0]     action_reg;
    lsc_pkg::mac_t                 peer_reg;
    lsc_pkg::mac_t                 reply_reg;
    logic                          running_reg;
    logic                          adv_reg;
    logic                          last_reg;
    logic                          load;
    logic                          final_slot;

    assign load       = head_valid && (!out_valid_reg || result.ready);
    assign final_slot = (slot_reg == (head.count - 2'd1));
    assign pop        = load && final_slot;
    assign slot_next  = final_slot ? '0 : slot_reg + 2'd1;

    assign result.valid          = out_valid_reg;
    assign result.action         = action_reg;
    assign result.peer_addr      = peer_reg;
    assign result.reply_to       = reply_reg;
    assign result.is_running     = running_reg;
    assign result.is_advertising = adv_reg;
    assign result.last           = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg  <= head.act[slot_reg];
            peer_reg    <= head.peer[slot_reg];
            reply_reg   <= head.reply[slot_reg];
            running_reg <= head.running;
            adv_reg     <= head.advertising;
            last_reg    <= final_slot;
        end
    end

endmodule
